// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the allocator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/ffa_pkg.sv =====
// Package of the first-fit block allocator: sizes, codes and the table entry type.
// Used by the channel interfaces and by the top level.
package ffa_pkg;

    localparam int POOL_BYTES   = 1048576;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int ALIGN_BYTES  = 8;
    localparam int SPLIT_MIN    = 8;

    localparam int SIZE_W = 21;
    localparam int ADDR_W = 20;
    localparam int NEED_W = SIZE_W + 1;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] payload;
    } entry_t;

    localparam entry_t INIT_ENTRY = '{free: 1'b1,
                                      payload: SIZE_W'(POOL_BYTES - HEADER_BYTES)};

endpackage

// ===== src/ffa_req_if.sv =====
// Request channel of the allocator: valid/ready handshake plus request fields.
// Depends on ffa_pkg for the field widths.
interface ffa_req_if;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [ffa_pkg::SIZE_W-1:0] request_size;
    logic [ffa_pkg::ADDR_W-1:0] address;

    modport source (output valid, operation, request_size, address, input ready);
    modport sink   (input valid, operation, request_size, address, output ready);
endinterface

// ===== src/ffa_resp_if.sv =====
// Response channel of the allocator: valid/ready handshake plus result fields.
// Depends on ffa_pkg for the field widths.
interface ffa_resp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [ffa_pkg::ADDR_W-1:0] granted_address;
    logic [ffa_pkg::SIZE_W-1:0] granted_bytes;

    modport source (output valid, status, granted_address, granted_bytes, input ready);
    modport sink   (input valid, status, granted_address, granted_bytes, output ready);
endinterface

// ===== src/first_fit_block_allocator.sv =====
// First-fit block allocator over a block table kept in one synchronous memory.
// Throughput: one request at a time. Each table entry visited costs a memory read,
// then an evaluate step; an allocate scans up to its block and, on a split, shifts the tail,
// and a free scans up to its block, then passes over the table; both bounded by the table depth.
// Reset: asynchronous, active low; the table holds one free block spanning the pool.
// The memory itself is not cleared; entry 0 reads as the pool block until written.
module first_fit_block_allocator (
    input  logic       clk,
    input  logic       rst_n,
    ffa_req_if.sink    req,
    ffa_resp_if.source resp
);
    import ffa_pkg::*;

    `include "assert_macros.svh"

    // Sequencer states. A request scans the table to find its block; an allocate
    // that splits then shifts the tail up to open a slot, and a free compacts the
    // table while merging runs of free blocks.
    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_SCAN_RD = 10'b0000000010,
        S_SCAN_EV = 10'b0000000100,
        S_SHIFT_RD= 10'b0000001000,
        S_SHIFT_WR= 10'b0000010000,
        S_SPLIT_WR= 10'b0000100000,
        S_MERGE_RD= 10'b0001000000,
        S_MERGE_EV= 10'b0010000000,
        S_MERGE_WR= 10'b0100000000,
        S_RESP    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Block table memory, one read and one write port.
    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;
    logic   rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic   wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t wr_data;

    // Entry 0 reads as the initial pool block until the first write to it.
    logic fresh_reg, fresh_next;
    logic rd_zero_reg;
    entry_t ent;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  m_reg, m_next;
    logic [IDX_W-1:0]  w_reg, w_next;
    logic [IDX_W-1:0]  match_reg, match_next;
    logic [SIZE_W-1:0] start_reg, start_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic              op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    entry_t            cur_reg, cur_next;

    logic [1:0]        res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [SIZE_W-1:0] res_bytes_reg, res_bytes_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [SIZE_W-1:0] out_bytes_reg, out_bytes_next;

    // Request size plus header, rounded up to the alignment.
    logic [NEED_W:0]   need_raw;
    logic [NEED_W-1:0] need_in;
    // Per-entry arithmetic during the scan.
    logic [NEED_W:0]   split_thresh;
    logic [NEED_W:0]   rem_wide;
    logic [SIZE_W:0]   pay_start;
    logic              is_last;
    logic              fits;
    logic              can_split;
    entry_t            ent_marked;

    assign need_raw = (NEED_W+1)'(req.request_size) + (NEED_W+1)'(HEADER_BYTES + ALIGN_BYTES - 1);
    assign need_in  = NEED_W'((need_raw / ALIGN_BYTES) * ALIGN_BYTES);

    assign ent          = rd_zero_reg ? INIT_ENTRY : rd_data_reg;
    assign split_thresh = (NEED_W+1)'(need_reg) + (NEED_W+1)'(HEADER_BYTES + SPLIT_MIN);
    assign rem_wide     = (NEED_W+1)'(ent.payload) - (NEED_W+1)'(need_reg)
                          - (NEED_W+1)'(HEADER_BYTES);
    assign pay_start    = (SIZE_W+1)'(start_reg) + (SIZE_W+1)'(HEADER_BYTES);
    assign is_last      = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
    assign fits         = ent.free && (NEED_W'(ent.payload) >= need_reg);
    assign can_split    = ((NEED_W+1)'(ent.payload) >= split_thresh)
                          && (cnt_reg < CNT_W'(MAX_BLOCKS));

    // During the merge pass the block being freed is marked free as it streams by.
    always_comb
    begin
        ent_marked = ent;
        if (idx_reg == match_reg)
        begin
            ent_marked.free = 1'b1;
        end
    end

    assign req.ready            = (state_reg == S_IDLE);
    assign resp.valid           = out_valid_reg;
    assign resp.status          = out_status_reg;
    assign resp.granted_address = out_addr_reg;
    assign resp.granted_bytes   = out_bytes_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        m_next          = m_reg;
        w_next          = w_reg;
        match_next      = match_reg;
        start_next      = start_reg;
        need_next       = need_reg;
        rem_next        = rem_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_bytes_next  = res_bytes_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_bytes_next  = out_bytes_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = ent;

        if (out_valid_reg && resp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.operation;
                    addr_next       = req.address;
                    need_next       = need_in;
                    idx_next        = '0;
                    start_next      = '0;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    res_bytes_next  = '0;
                    if (req.operation == OP_ALLOC && req.request_size == '0)
                    begin
                        res_status_next = ST_ZERO_SIZE;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                if (op_reg == OP_ALLOC && fits)
                begin
                    // Claim this block; a split keeps only the rounded size here.
                    wr_en         = 1'b1;
                    wr_addr       = idx_reg;
                    wr_data.free  = 1'b0;
                    wr_data.payload = can_split ? SIZE_W'(need_reg) : ent.payload;
                    res_addr_next = ADDR_W'(pay_start);
                    res_bytes_next = wr_data.payload;
                    if (can_split)
                    begin
                        rem_next = SIZE_W'(rem_wide);
                        m_next   = IDX_W'(cnt_reg);
                        if (IDX_W'(cnt_reg) == idx_reg + IDX_W'(1))
                        begin
                            state_next = S_SPLIT_WR;
                        end
                        else
                        begin
                            state_next = S_SHIFT_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (op_reg == OP_FREE && pay_start == (SIZE_W+1)'(addr_reg))
                begin
                    match_next = idx_reg;
                    idx_next   = '0;
                    w_next     = '0;
                    state_next = S_MERGE_RD;
                end
                else if (is_last)
                begin
                    res_status_next = (op_reg == OP_ALLOC) ? ST_NO_SPACE : ST_BAD_ADDR;
                    state_next      = S_RESP;
                end
                else
                begin
                    start_next = SIZE_W'(pay_start + (SIZE_W+1)'(ent.payload));
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = m_reg - IDX_W'(1);
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = m_reg;
                wr_data = ent;
                m_next  = m_reg - IDX_W'(1);
                if (m_reg - IDX_W'(1) == idx_reg + IDX_W'(1))
                begin
                    state_next = S_SPLIT_WR;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SPLIT_WR:
            begin
                wr_en           = 1'b1;
                wr_addr         = idx_reg + IDX_W'(1);
                wr_data.free    = 1'b1;
                wr_data.payload = rem_reg;
                cnt_next        = cnt_reg + CNT_W'(1);
                state_next      = S_RESP;
            end
            S_MERGE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_MERGE_EV;
            end
            S_MERGE_EV:
            begin
                // Fold a free entry into a free accumulator; otherwise retire
                // the accumulator to the write slot and start a new one.
                if (idx_reg == '0)
                begin
                    cur_next = ent_marked;
                end
                else if (cur_reg.free && ent_marked.free)
                begin
                    cur_next.payload = cur_reg.payload + ent_marked.payload
                                       + SIZE_W'(HEADER_BYTES);
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = w_reg;
                    wr_data  = cur_reg;
                    w_next   = w_reg + IDX_W'(1);
                    cur_next = ent_marked;
                end
                if (is_last)
                begin
                    state_next = S_MERGE_WR;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_MERGE_RD;
                end
            end
            S_MERGE_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = w_reg;
                wr_data    = cur_reg;
                cnt_next   = CNT_W'(w_reg) + CNT_W'(1);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || resp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_bytes_next  = res_bytes_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        fresh_next = fresh_reg && !(wr_en && wr_addr == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= CNT_W'(1);
            fresh_reg     <= 1'b1;
            rd_zero_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fresh_reg     <= fresh_next;
            if (rd_en)
            begin
                rd_zero_reg <= fresh_reg && (rd_addr == '0);
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        m_reg          <= m_next;
        w_reg          <= w_next;
        match_reg      <= match_next;
        start_reg      <= start_next;
        need_reg       <= need_next;
        rem_reg        <= rem_next;
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_bytes_reg  <= res_bytes_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_bytes_reg  <= out_bytes_next;
    end

    // The table always holds at least one block and never more than its depth.
    `ASSERT_ALWAYS(a_count_range, (cnt_reg != '0) && (cnt_reg <= CNT_W'(MAX_BLOCKS)))
    // A split only happens while the table has a free slot.
    `ASSERT_ALWAYS(a_split_room, (state_reg != S_SPLIT_WR) || (cnt_reg < CNT_W'(MAX_BLOCKS)))
    // A zero-size allocate goes straight to the response stage.
    `ASSERT_NEXT(a_zero_fast, req.valid && req.ready && req.operation == OP_ALLOC && req.request_size == '0, state_reg == S_RESP)

endmodule
